### sv/battery_mode_sequencer_unit_defines.svh
// Assertion macros shared by the battery mode sequencer checkers.
// Needs nothing else; take it in with an include of the bare file name.
`ifndef BATTERY_MODE_SEQUENCER_UNIT_DEFINES_SVH
`define BATTERY_MODE_SEQUENCER_UNIT_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define BMSU_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked assertion that also holds across reset.
`define BMSU_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### sv/bmsu_pkg.sv
// Types, constants and helper functions for the battery mode sequencer.
// Used by the top level and by its checker; depends on nothing.
`default_nettype none

package bmsu_pkg;

    // Field widths.
    localparam int VOLT_W    = 14;
    localparam int TIME_W    = 32;
    localparam int CNT_W     = 3;
    localparam int MODE_W    = 3;
    localparam int EVENT_W   = 2;
    localparam int CFG_IDX_W = 3;

    // Register values after reset; the boot wait spans twenty-six orbits.
    localparam logic [VOLT_W-1:0] CRITICAL_MV_RST   = VOLT_W'(3000);
    localparam logic [VOLT_W-1:0] DOWN_MV_RST       = VOLT_W'(3400);
    localparam logic [VOLT_W-1:0] LOW_POWER_MV_RST  = VOLT_W'(3600);
    localparam logic [VOLT_W-1:0] FLASH_AVG_MV_RST  = VOLT_W'(3800);
    localparam logic [TIME_W-1:0] MIN_INITIAL_S_RST = TIME_W'(30 * 60);
    localparam logic [TIME_W-1:0] ORBIT_LENGTH_S    = TIME_W'(5400);
    localparam logic [TIME_W-1:0] MIN_BOOT_S_RST    = TIME_W'(26) * ORBIT_LENGTH_S;
    localparam logic [CNT_W-1:0]  CONFIRM_COUNT_RST = CNT_W'(5);

    // Operation carried by an input beat.
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Operating modes.
    typedef enum logic [MODE_W-1:0] {
        MODE_INITIAL    = 3'd0,
        MODE_ANTENNA    = 3'd1,
        MODE_HELLO      = 3'd2,
        MODE_HELLO_LP   = 3'd3,
        MODE_IDLE       = 3'd4,
        MODE_IDLE_FLASH = 3'd5,
        MODE_LOW_POWER  = 3'd6,
        MODE_EOL        = 3'd7
    } mode_t;

    // Event codes reported with each result.
    typedef enum logic [EVENT_W-1:0] {
        EV_NONE      = 2'd0,
        EV_EOL       = 2'd1,
        EV_UNCERTAIN = 2'd2
    } event_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CRITICAL_MV   = 3'd0,
        CFG_DOWN_MV       = 3'd1,
        CFG_LOW_POWER_MV  = 3'd2,
        CFG_FLASH_AVG_MV  = 3'd3,
        CFG_MIN_INITIAL_S = 3'd4,
        CFG_MIN_BOOT_S    = 3'd5,
        CFG_CONFIRM_COUNT = 3'd6
    } cfg_idx_t;

    // Input beat.
    typedef struct packed {
        logic              opcode;
        logic [VOLT_W-1:0] main_a_mv;
        logic [VOLT_W-1:0] main_b_mv;
        logic [VOLT_W-1:0] bank1_a_mv;
        logic [VOLT_W-1:0] bank1_b_mv;
        logic [VOLT_W-1:0] bank2_a_mv;
        logic [VOLT_W-1:0] bank2_b_mv;
        logic [TIME_W-1:0] now_s;
        logic              main_a_charged;
        logic              main_b_charged;
        logic [MODE_W-1:0] write_mode;
    } in_beat_t;

    // Result beat.
    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic               mode_changed;
        logic               confirming;
        logic [EVENT_W-1:0] event_res;
    } out_beat_t;

    // Low-power mode that a failed end-of-life check falls back to; initial and antenna map to themselves.
    function automatic mode_t fallback_mode(input mode_t m);
        mode_t f;
        f = MODE_INITIAL;
        case (m) inside
            MODE_INITIAL, MODE_ANTENNA:                  f = m;
            MODE_HELLO, MODE_HELLO_LP:                   f = MODE_HELLO_LP;
            MODE_IDLE, MODE_IDLE_FLASH, MODE_LOW_POWER:  f = MODE_LOW_POWER;
            default:                                     f = MODE_INITIAL;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

### sv/battery_mode_sequencer_unit.sv
// Battery mode sequencer: eight-mode power sequencer with end-of-life check.
// Depends on bmsu_pkg.
//
//  Channel | Ports                                  | Direction
//  --------+----------------------------------------+----------
//  input   | s_valid, s_ready, s_data               | in
//  result  | m_valid, m_ready, m_data               | out
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// Each beat passes an input register, then one compare-and-select stage that
// updates the mode state and loads the result register; one beat per cycle is
// sustained while the result is taken, set by the single state update per beat.
// Reset is synchronous and active low; it empties both registers and restores
// the configuration defaults. A stalled result holds while the input register
// still takes one more beat; configuration writes are always accepted.
`default_nettype none

module battery_mode_sequencer_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  bmsu_pkg::in_beat_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output bmsu_pkg::out_beat_t                 m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bmsu_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bmsu_pkg::TIME_W-1:0]         cfg_data
);

    // Configuration registers.
    logic [bmsu_pkg::VOLT_W-1:0] critical_mv_reg;
    logic [bmsu_pkg::VOLT_W-1:0] down_mv_reg;
    logic [bmsu_pkg::VOLT_W-1:0] low_power_mv_reg;
    logic [bmsu_pkg::VOLT_W-1:0] flash_avg_mv_reg;
    logic [bmsu_pkg::TIME_W-1:0] min_initial_s_reg;
    logic [bmsu_pkg::TIME_W-1:0] min_boot_s_reg;
    logic [bmsu_pkg::CNT_W-1:0]  confirm_count_reg;

    // Pipeline and mode state.
    logic                         in_valid_reg;
    bmsu_pkg::in_beat_t           in_data_reg;
    logic                         out_valid_reg;
    bmsu_pkg::out_beat_t          out_data_reg;
    bmsu_pkg::out_beat_t          out_data_next;
    bmsu_pkg::mode_t              mode_reg;
    bmsu_pkg::mode_t              mode_next;
    logic [bmsu_pkg::CNT_W-1:0]   confirm_reg;
    logic [bmsu_pkg::CNT_W-1:0]   confirm_next;
    logic                         advance;

    // Working signals of the decision stage.
    logic [bmsu_pkg::VOLT_W:0]    bank1_sum;
    logic [bmsu_pkg::VOLT_W:0]    bank2_sum;
    logic [bmsu_pkg::VOLT_W-1:0]  bank1_avg;
    logic [bmsu_pkg::VOLT_W-1:0]  bank2_avg;
    logic                         crit;
    logic                         both_above_down;
    logic                         one_below_lp;
    logic                         flash_ok;
    logic                         charged;
    bmsu_pkg::mode_t              rule_mode;
    bmsu_pkg::mode_t              fall_mode;
    bmsu_pkg::event_t             ev;

    // Handshakes.
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;
    assign cfg_ready = 1'b1;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            critical_mv_reg   <= bmsu_pkg::CRITICAL_MV_RST;
            down_mv_reg       <= bmsu_pkg::DOWN_MV_RST;
            low_power_mv_reg  <= bmsu_pkg::LOW_POWER_MV_RST;
            flash_avg_mv_reg  <= bmsu_pkg::FLASH_AVG_MV_RST;
            min_initial_s_reg <= bmsu_pkg::MIN_INITIAL_S_RST;
            min_boot_s_reg    <= bmsu_pkg::MIN_BOOT_S_RST;
            confirm_count_reg <= bmsu_pkg::CONFIRM_COUNT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                bmsu_pkg::CFG_CRITICAL_MV:   critical_mv_reg   <= cfg_data[bmsu_pkg::VOLT_W-1:0];
                bmsu_pkg::CFG_DOWN_MV:       down_mv_reg       <= cfg_data[bmsu_pkg::VOLT_W-1:0];
                bmsu_pkg::CFG_LOW_POWER_MV:  low_power_mv_reg  <= cfg_data[bmsu_pkg::VOLT_W-1:0];
                bmsu_pkg::CFG_FLASH_AVG_MV:  flash_avg_mv_reg  <= cfg_data[bmsu_pkg::VOLT_W-1:0];
                bmsu_pkg::CFG_MIN_INITIAL_S: min_initial_s_reg <= cfg_data;
                bmsu_pkg::CFG_MIN_BOOT_S:    min_boot_s_reg    <= cfg_data;
                bmsu_pkg::CFG_CONFIRM_COUNT: confirm_count_reg <= cfg_data[bmsu_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Threshold tests on the registered sample.
    always_comb begin
        bank1_sum = {1'b0, in_data_reg.bank1_a_mv} + {1'b0, in_data_reg.bank1_b_mv};
        bank2_sum = {1'b0, in_data_reg.bank2_a_mv} + {1'b0, in_data_reg.bank2_b_mv};
        bank1_avg = bank1_sum[bmsu_pkg::VOLT_W:1];
        bank2_avg = bank2_sum[bmsu_pkg::VOLT_W:1];
        crit            = (in_data_reg.main_a_mv <= critical_mv_reg) &&
                          (in_data_reg.main_b_mv <= critical_mv_reg);
        both_above_down = (in_data_reg.main_a_mv > down_mv_reg) &&
                          (in_data_reg.main_b_mv > down_mv_reg);
        one_below_lp    = (in_data_reg.main_a_mv <= low_power_mv_reg) ||
                          (in_data_reg.main_b_mv <= low_power_mv_reg);
        flash_ok        = (bank1_avg > flash_avg_mv_reg) || (bank2_avg > flash_avg_mv_reg);
        charged         = in_data_reg.main_a_charged && in_data_reg.main_b_charged;
    end

    // Normal mode transitions; antenna deploy is never left by these rules.
    always_comb begin
        rule_mode = mode_reg;
        case (mode_reg)
            bmsu_pkg::MODE_INITIAL: begin
                if ((in_data_reg.now_s > min_initial_s_reg) && both_above_down && charged) begin
                    rule_mode = bmsu_pkg::MODE_ANTENNA;
                end
            end
            bmsu_pkg::MODE_HELLO: begin
                if (!both_above_down) begin
                    rule_mode = bmsu_pkg::MODE_HELLO_LP;
                end else if (in_data_reg.now_s > min_boot_s_reg) begin
                    rule_mode = bmsu_pkg::MODE_IDLE;
                end
            end
            bmsu_pkg::MODE_HELLO_LP: begin
                if (both_above_down) begin
                    rule_mode = bmsu_pkg::MODE_HELLO;
                end
            end
            bmsu_pkg::MODE_IDLE: begin
                if (one_below_lp) begin
                    rule_mode = bmsu_pkg::MODE_LOW_POWER;
                end else if (flash_ok) begin
                    rule_mode = bmsu_pkg::MODE_IDLE_FLASH;
                end
            end
            bmsu_pkg::MODE_IDLE_FLASH: begin
                if (one_below_lp) begin
                    rule_mode = bmsu_pkg::MODE_LOW_POWER;
                end else if (!flash_ok) begin
                    rule_mode = bmsu_pkg::MODE_IDLE;
                end
            end
            bmsu_pkg::MODE_LOW_POWER: begin
                if (both_above_down) begin
                    rule_mode = bmsu_pkg::MODE_IDLE;
                end
            end
            default: rule_mode = mode_reg;
        endcase
    end

    // Mode and confirmation update for the beat in the input register.
    always_comb begin
        fall_mode    = bmsu_pkg::fallback_mode(mode_reg);
        mode_next    = mode_reg;
        confirm_next = confirm_reg;
        ev           = bmsu_pkg::EV_NONE;
        if (mode_reg != bmsu_pkg::MODE_EOL) begin
            if (in_data_reg.opcode == bmsu_pkg::OP_WRITE) begin
                mode_next    = bmsu_pkg::mode_t'(in_data_reg.write_mode);
                confirm_next = '0;
            end else if (confirm_reg != '0) begin
                if (crit) begin
                    confirm_next = confirm_reg - bmsu_pkg::CNT_W'(1);
                    if (confirm_next == '0) begin
                        mode_next = bmsu_pkg::MODE_EOL;
                        ev        = bmsu_pkg::EV_EOL;
                    end
                end else begin
                    confirm_next = '0;
                    ev           = bmsu_pkg::EV_UNCERTAIN;
                    mode_next    = (fall_mode != mode_reg) ? fall_mode : rule_mode;
                end
            end else if (crit) begin
                if (confirm_count_reg == '0) begin
                    mode_next = bmsu_pkg::MODE_EOL;
                    ev        = bmsu_pkg::EV_EOL;
                end else begin
                    confirm_next = confirm_count_reg;
                end
            end else begin
                mode_next = rule_mode;
            end
            if (mode_next == bmsu_pkg::MODE_EOL) begin
                confirm_next = '0;
            end
        end
        out_data_next.mode         = mode_next;
        out_data_next.mode_changed = (mode_next != mode_reg);
        out_data_next.confirming   = (confirm_next != '0);
        out_data_next.event_res    = ev;
    end

    // Control registers: pipeline valids and mode state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= bmsu_pkg::MODE_INITIAL;
            confirm_reg   <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                mode_reg      <= mode_next;
                confirm_reg   <= confirm_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire

### sv/bmsu_checker.sv
// Port-level checker for the battery mode sequencer, bound to its top level.
// Depends on bmsu_pkg and battery_mode_sequencer_unit_defines.svh.
`default_nettype none
`include "battery_mode_sequencer_unit_defines.svh"

module bmsu_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input bmsu_pkg::out_beat_t m_data
);

    logic stalled;
    logic eol_event;
    logic eol_entry_ok;
    logic known_event;
    logic event_while_confirming;
    logic eol_mode;

    // Shorthand terms for the properties below.
    assign stalled                = m_valid && !m_ready;
    assign eol_event              = m_valid && (m_data.event_res == bmsu_pkg::EV_EOL);
    assign eol_entry_ok           = (m_data.mode == bmsu_pkg::MODE_EOL) &&
                                    m_data.mode_changed && !m_data.confirming;
    assign known_event            = (m_data.event_res == bmsu_pkg::EV_NONE) ||
                                    (m_data.event_res == bmsu_pkg::EV_EOL) ||
                                    (m_data.event_res == bmsu_pkg::EV_UNCERTAIN);
    assign event_while_confirming = m_data.confirming &&
                                    (m_data.event_res != bmsu_pkg::EV_NONE);
    assign eol_mode               = m_valid && (m_data.mode == bmsu_pkg::MODE_EOL);

    // Reset leaves no result beat pending.
    `BMSU_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid, "result valid after reset")

    // A stalled result beat holds.
    `BMSU_ASSERT(a_hold, aclk, aresetn, stalled |=> m_valid && $stable(m_data), "beat changed")

    // Entering end of life is a mode change into end of life with no confirmation.
    `BMSU_ASSERT(a_eol_entry, aclk, aresetn, eol_event |-> eol_entry_ok, "bad end-of-life beat")

    // Only defined event codes appear, and a confirmation in progress reports none.
    `BMSU_ASSERT(a_confirm_event, aclk, aresetn, m_valid |-> known_event && !event_while_confirming, "bad event")

    // End of life never confirms.
    `BMSU_ASSERT(a_eol_quiet, aclk, aresetn, eol_mode |-> !m_data.confirming, "confirming in end of life")

endmodule

bind battery_mode_sequencer_unit bmsu_checker u_bmsu_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
